// ----- sv/lpde_pkg.sv -----
// Shared types and constants for the Legendre polynomial evaluator.
package lpde_pkg;

  // Field widths of the result channel
  localparam int W_DEGREE = 4;
  localparam int W_COORD  = 18;
  localparam int W_VAL    = 18;
  localparam int W_D1     = 23;
  localparam int W_D2     = 28;

  // Reciprocal scaling: R_n = round(2^RECIP_BITS / n)
  localparam int RECIP_BITS    = 24;
  localparam int RECIP_W       = 25;
  localparam int RECIP_ENTRIES = 17;

  localparam logic [RECIP_W-1:0] RECIP [RECIP_ENTRIES] = '{
    25'd0,       25'd16777216, 25'd8388608, 25'd5592405, 25'd4194304,
    25'd3355443, 25'd2796203,  25'd2396745, 25'd2097152, 25'd1864135,
    25'd1677722, 25'd1525201,  25'd1398101, 25'd1290555, 25'd1198373,
    25'd1118481, 25'd1048576
  };

  // Reset value of the degree register
  localparam logic [W_DEGREE-1:0] DEG_RESET = 4'd10;

  // One evaluated degree
  typedef struct packed {
    logic signed [W_VAL-1:0] poly_value;
    logic signed [W_D1-1:0]  first_deriv;
    logic signed [W_D2-1:0]  second_deriv;
  } res_t;

  // Control that travels with each coordinate down the pipeline
  typedef struct packed {
    logic                      vld;
    logic [W_DEGREE-1:0]       top;
    logic signed [W_COORD-1:0] x;
  } ctl_t;

endpackage

// ----- sv/lpde_step.sv -----
// One recurrence step of the Legendre pipeline: derives degree DEG in three stages.
module lpde_step #(
  parameter int MAX_DEGREE = 10,
  parameter int FRAC_BITS  = 16,
  parameter int DEG        = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  lpde_pkg::ctl_t                  in_ctl,
  input  lpde_pkg::res_t [MAX_DEGREE:0]   in_res,
  output lpde_pkg::ctl_t                  out_ctl,
  output lpde_pkg::res_t [MAX_DEGREE:0]   out_res
);
  import lpde_pkg::*;

  // Working widths, with a guard bit over the largest term
  localparam int TW  = ((42 > 23 + FRAC_BITS) ? 42 : 23 + FRAC_BITS) + 1;
  localparam int DW  = ((42 > 24 + FRAC_BITS) ? 42 : 24 + FRAC_BITS) + 1;
  localparam int DDW = ((47 > 29 + FRAC_BITS) ? 47 : 29 + FRAC_BITS) + 1;
  // Numerator keeps every bit left after the rounding shift
  localparam int QW  = TW - FRAC_BITS;
  localparam int PW  = QW + RECIP_W + 1;

  localparam logic signed [TW-1:0]  KA     = TW'(2 * DEG - 1);
  localparam logic signed [TW-1:0]  KB     = TW'(DEG - 1);
  localparam logic signed [TW-1:0]  T_HALF = TW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [DW-1:0]  KD     = DW'(DEG);
  localparam logic signed [DW-1:0]  D_HALF = DW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [DDW-1:0] KE     = DDW'(DEG + 1);
  localparam logic signed [DDW-1:0] E_HALF = DDW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [PW-1:0]  RC     = PW'(RECIP[DEG]);
  localparam logic signed [PW-1:0]  P_HALF = PW'(1) <<< (RECIP_BITS - 1);

  // Stage 1: products with x
  ctl_t                     c1_r;
  res_t [MAX_DEGREE:0]      r1_r;
  logic signed [35:0]       m0_r, m0_nxt;
  logic signed [40:0]       m1_r, m1_nxt;
  logic signed [45:0]       m2_r, m2_nxt;

  assign m0_nxt = in_ctl.x * in_res[DEG-1].poly_value;
  assign m1_nxt = in_ctl.x * in_res[DEG-1].first_deriv;
  assign m2_nxt = in_ctl.x * in_res[DEG-1].second_deriv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r <= '0;
    end else if (adv) begin
      c1_r <= in_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r1_r <= in_res;
      m0_r <= m0_nxt;
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
    end
  end

  // Stage 2: weighted sums, round to nearest (ties away from zero), saturate
  logic signed [TW-1:0]  t_sum, t_rnd, q_full;
  logic signed [DW-1:0]  d_sum, d_rnd, d_full;
  logic signed [DDW-1:0] e_sum, e_rnd, e_full;
  logic signed [QW-1:0]  q_nxt, q_r;
  logic signed [W_D1-1:0] d_nxt, d_r;
  logic signed [W_D2-1:0] dd_nxt, dd_r;
  logic                   q_fit, d_fit, e_fit;
  ctl_t                   c2_r;
  res_t [MAX_DEGREE:0]    r2_r;

  assign t_sum  = TW'(m0_r) * KA - ((TW'(r1_r[DEG-2].poly_value) * KB) <<< FRAC_BITS);
  assign t_rnd  = t_sum + T_HALF - TW'(t_sum[TW-1]);
  assign q_full = t_rnd >>> FRAC_BITS;
  assign q_fit  = (&q_full[TW-1:QW-1]) | ~(|q_full[TW-1:QW-1]);
  assign q_nxt  = q_fit ? q_full[QW-1:0] : {q_full[TW-1], {(QW-1){~q_full[TW-1]}}};

  assign d_sum  = ((DW'(r1_r[DEG-1].poly_value) * KD) <<< FRAC_BITS) + DW'(m1_r);
  assign d_rnd  = d_sum + D_HALF - DW'(d_sum[DW-1]);
  assign d_full = d_rnd >>> FRAC_BITS;
  assign d_fit  = (&d_full[DW-1:W_D1-1]) | ~(|d_full[DW-1:W_D1-1]);
  assign d_nxt  = d_fit ? d_full[W_D1-1:0] : {d_full[DW-1], {(W_D1-1){~d_full[DW-1]}}};

  assign e_sum  = ((DDW'(r1_r[DEG-1].first_deriv) * KE) <<< FRAC_BITS) + DDW'(m2_r);
  assign e_rnd  = e_sum + E_HALF - DDW'(e_sum[DDW-1]);
  assign e_full = e_rnd >>> FRAC_BITS;
  assign e_fit  = (&e_full[DDW-1:W_D2-1]) | ~(|e_full[DDW-1:W_D2-1]);
  assign dd_nxt = e_fit ? e_full[W_D2-1:0] : {e_full[DDW-1], {(W_D2-1){~e_full[DDW-1]}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r <= '0;
    end else if (adv) begin
      c2_r <= c1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r2_r <= r1_r;
      q_r  <= q_nxt;
      d_r  <= d_nxt;
      dd_r <= dd_nxt;
    end
  end

  // Stage 3: divide the numerator by n through the reciprocal, store degree DEG
  logic signed [PW-1:0]       p_prod, p_rnd, p_full;
  logic                       p_fit;
  logic signed [W_VAL-1:0]    v_val;
  res_t [MAX_DEGREE:0]        r3_nxt, r3_r;
  ctl_t                       c3_r;

  assign p_prod = PW'(q_r) * RC;
  assign p_rnd  = p_prod + P_HALF - PW'(p_prod[PW-1]);
  assign p_full = p_rnd >>> RECIP_BITS;
  assign p_fit  = (&p_full[PW-1:W_VAL-1]) | ~(|p_full[PW-1:W_VAL-1]);
  assign v_val  = p_fit ? p_full[W_VAL-1:0] : {p_full[PW-1], {(W_VAL-1){~p_full[PW-1]}}};

  always_comb begin
    r3_nxt                   = r2_r;
    r3_nxt[DEG].poly_value   = v_val;
    r3_nxt[DEG].first_deriv  = d_r;
    r3_nxt[DEG].second_deriv = dd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c3_r <= '0;
    end else if (adv) begin
      c3_r <= c2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3_r <= r3_nxt;
    end
  end

  assign out_ctl = c3_r;
  assign out_res = r3_r;

endmodule

// ----- sv/legendre_poly_deriv_eval_unit.sv -----
// Top level of the Legendre polynomial evaluator: P_n, P_n' and P_n'' for n = 0 .. top.
//
// Usage:
//   in_*  : one coordinate x per transaction, signed with FRAC_BITS fractional bits.
//   out_* : for each coordinate, top+1 transactions in degree order 0 .. top, where
//           top = min(degree register, MAX_DEGREE); out_tlast marks degree top.
//   cfg_* : cfg_wr_en writes the degree register; write it only while the block is idle.
// Pipeline: after its coordinate is taken, the degree 0 result passes one input stage,
//   three stages for each degree from 2 to MAX_DEGREE and the output holding
//   register.
// Throughput: one result transaction per cycle while out_tready is high; the output
//   holding register that walks the finished degrees sets that rate. The
//   pipeline takes a new coordinate every cycle while it has room.
// Reset: rst_n low clears the pipeline valid bits and the output register and sets the
//   degree register to 10.
// Stall: while out_tready is low the current result holds; the pipeline keeps advancing
//   until a coordinate reaches its last stage and then stalls as a whole, dropping nothing.
module legendre_poly_deriv_eval_unit #(
  parameter int MAX_DEGREE = 10,
  parameter int FRAC_BITS  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [3:0]  cfg_wr_data,   // degree_in_use
  // coordinate channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,      // [17:0] coord
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,     // [3:0] degree, [21:4] poly_value,
                                     // [44:22] first_deriv, [72:45] second_deriv
  output logic        out_tlast
);
  import lpde_pkg::*;

  localparam int IW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE + 1) : 1;
  localparam logic signed [W_VAL-1:0] ONE_V =
    (FRAC_BITS >= W_VAL - 1) ? {1'b0, {(W_VAL-1){1'b1}}} : W_VAL'(1 << FRAC_BITS);
  localparam logic signed [W_D1-1:0]  ONE_D =
    (FRAC_BITS >= W_D1 - 1) ? {1'b0, {(W_D1-1){1'b1}}} : W_D1'(1 << FRAC_BITS);

  // Degree register
  logic [W_DEGREE-1:0] degree_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= DEG_RESET;
    end else if (cfg_wr_en) begin
      degree_r <= cfg_wr_data;
    end
  end

  // Pipeline advance and output buffer handshake
  logic                 adv;
  logic                 buf_ready;
  logic                 fire;
  logic                 done;
  logic                 load;
  ctl_t                 tail_ctl;
  res_t [MAX_DEGREE:0]  tail_res;

  // Stage 0: seed degrees 0 and 1
  ctl_t                 c0_r, c0_nxt;
  res_t [MAX_DEGREE:0]  r0_r, r0_nxt;

  always_comb begin
    c0_nxt.vld = in_tvalid;
    c0_nxt.top = (5'(degree_r) > 5'(MAX_DEGREE)) ? W_DEGREE'(MAX_DEGREE) : degree_r;
    c0_nxt.x   = in_tdata[W_COORD-1:0];
  end

  always_comb begin
    r0_nxt                 = '0;
    r0_nxt[0].poly_value   = ONE_V;
    r0_nxt[1].poly_value   = in_tdata[W_COORD-1:0];
    r0_nxt[1].first_deriv  = ONE_D;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r <= '0;
    end else if (adv) begin
      c0_r <= c0_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r0_r <= r0_nxt;
    end
  end

  // Recurrence chain, one step per degree from 2 upwards
  ctl_t                 ch_ctl [1:MAX_DEGREE];
  res_t [MAX_DEGREE:0]  ch_res [1:MAX_DEGREE];

  assign ch_ctl[1] = c0_r;
  assign ch_res[1] = r0_r;

  for (genvar g = 2; g <= MAX_DEGREE; g++) begin : g_step
    lpde_step #(
      .MAX_DEGREE (MAX_DEGREE),
      .FRAC_BITS  (FRAC_BITS),
      .DEG        (g)
    ) u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .in_ctl  (ch_ctl[g-1]),
      .in_res  (ch_res[g-1]),
      .out_ctl (ch_ctl[g]),
      .out_res (ch_res[g])
    );
  end

  assign tail_ctl = ch_ctl[MAX_DEGREE];
  assign tail_res = ch_res[MAX_DEGREE];

  // Output holding register: walk the finished degrees one transaction at a time
  logic                 hold_valid_r, hold_valid_nxt;
  logic [W_DEGREE-1:0]  hold_top_r;
  res_t [MAX_DEGREE:0]  hold_res_r;
  logic [IW-1:0]        cnt_r, cnt_nxt;
  res_t                 sel;

  assign fire      = hold_valid_r & out_tready;
  assign done      = fire & (cnt_r == IW'(hold_top_r));
  assign buf_ready = ~hold_valid_r | done;
  assign adv       = ~tail_ctl.vld | buf_ready;
  assign load      = tail_ctl.vld & buf_ready;
  assign in_tready = adv;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    cnt_nxt        = cnt_r;
    if (load) begin
      hold_valid_nxt = 1'b1;
      cnt_nxt        = '0;
    end else if (done) begin
      hold_valid_nxt = 1'b0;
    end else if (fire) begin
      cnt_nxt        = cnt_r + IW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      cnt_r        <= '0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold_res_r <= tail_res;
      hold_top_r <= tail_ctl.top;
    end
  end

  // Drive the result channel
  assign sel        = hold_res_r[cnt_r];
  assign out_tvalid = hold_valid_r;
  assign out_tlast  = (cnt_r == IW'(hold_top_r));
  assign out_tdata  = {7'd0, sel.second_deriv, sel.first_deriv, sel.poly_value,
                       W_DEGREE'(cnt_r)};

  // Checks
  a_cnt_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> (cnt_r <= IW'(hold_top_r)))
    else $error("degree counter passed the top degree");

  a_new_run_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && out_tlast) |=> (!hold_valid_r || cnt_r == '0))
    else $error("run did not restart at degree zero after the last result");

  a_tail_held: assert property (@(posedge clk) disable iff (!rst_n)
    (tail_ctl.vld && !buf_ready) |=> (tail_ctl.vld && $stable(tail_ctl.x)))
    else $error("pipeline tail moved while the output register was busy");

  a_degree0_one: assert property (@(posedge clk) disable iff (!rst_n)
    (hold_valid_r && cnt_r == '0) |-> (sel.poly_value == ONE_V))
    else $error("degree zero value is not one");

endmodule

// ----- dv/tb_legendre_poly_deriv_eval_unit.sv -----
// Self-checking testbench for the Legendre polynomial evaluator with a randomised stream.
module tb_legendre_poly_deriv_eval_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import lpde_pkg::*;

  localparam int MAX_DEG      = 10;
  localparam int FRAC         = 16;
  localparam int RECIP_SHIFT  = 24;
  localparam int IN_W         = 24;
  localparam int OFS_VAL      = W_DEGREE;
  localparam int OFS_D1       = OFS_VAL + W_VAL;
  localparam int OFS_D2       = OFS_D1 + W_D1;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 40;
  localparam int GAP_PCT      = 14;

  // Corner coordinates: zero, +/-1.0, one LSB, just inside 1.0, halves, field limits
  localparam int CORNER_X [16] = '{
    0, 65536, -65536, 1, -1, 65535, -65535, 32768, -32768,
    131071, -131072, 98304, -98304, 21845, 3, 174762
  };

  // One expected result transaction
  typedef struct {
    logic [W_DEGREE-1:0] degree;
    logic [W_VAL-1:0]    poly_value;
    logic [W_D1-1:0]     first_deriv;
    logic [W_D2-1:0]     second_deriv;
    logic                last;
  } basis_res_t;

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              cfg_wr_en   = 1'b0;
  logic [3:0]        cfg_wr_data = '0;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata    = '0;   // [17:0] coord
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [79:0]       out_tdata;          // [3:0] degree, [21:4] poly_value,
                                         // [44:22] first_deriv, [72:45] second_deriv
  logic              out_tlast;

  logic [W_COORD-1:0] coord_q [$];
  basis_res_t         basis_q [$];
  logic [3:0]         degree_shadow = DEG_RESET;
  int                 n_errors      = 0;
  int                 quiet_cycles  = 0;
  bit                 calm          = 1'b0;

  legendre_poly_deriv_eval_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

  always #10 clk = ~clk;

  // Clamp to the signed range of a w-bit field
  function automatic longint sat_to(longint v, int w);
    longint hi, lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // Drop s fractional bits, rounding to nearest with ties away from zero
  function automatic longint round_away(longint v, int s);
    longint mag, r;
    mag = (v < 0) ? -v : v;
    r   = (mag + (longint'(1) <<< (s - 1))) >>> s;
    return (v < 0) ? -r : r;
  endfunction

  // Run the recurrences for one coordinate and queue one result per degree
  function automatic void expand_coord(logic [W_COORD-1:0] raw);
    longint one, x, pv, pd, pdd, ppv, v, d, dd, q, nn, recip;
    int top;
    basis_res_t r;
    one = longint'(1) <<< FRAC;
    x   = longint'($signed(raw));
    pv  = 0;
    pd  = 0;
    pdd = 0;
    ppv = 0;
    top = (degree_shadow > MAX_DEG) ? MAX_DEG : int'(degree_shadow);
    for (int n = 0; n <= top; n++) begin
      if (n == 0) begin
        v  = sat_to(one, W_VAL);
        d  = 0;
        dd = 0;
      end else if (n == 1) begin
        v  = sat_to(x, W_VAL);
        d  = sat_to(one, W_D1);
        dd = 0;
      end else begin
        nn    = n;
        recip = ((longint'(1) <<< RECIP_SHIFT) + nn / 2) / nn;
        q     = round_away((2 * nn - 1) * x * pv - (nn - 1) * ppv * one, FRAC);
        v     = sat_to(round_away(q * recip, RECIP_SHIFT), W_VAL);
        d     = sat_to(round_away(nn * pv * one + x * pd, FRAC), W_D1);
        dd    = sat_to(round_away((nn + 1) * pd * one + x * pdd, FRAC), W_D2);
      end
      r.degree       = W_DEGREE'(n);
      r.poly_value   = v[W_VAL-1:0];
      r.first_deriv  = d[W_D1-1:0];
      r.second_deriv = dd[W_D2-1:0];
      r.last         = (n == top);
      basis_q.push_back(r);
      ppv = pv;
      pv  = v;
      pd  = d;
      pdd = dd;
    end
  endfunction

  // Wait until every coordinate is taken and every result has come back
  task automatic settle();
    @(negedge clk);
    while (coord_q.size() != 0 || in_tvalid || basis_q.size() != 0) @(negedge clk);
  endtask

  // Write the degree register for one cycle while the block is idle
  task automatic set_degree(logic [3:0] v);
    @(posedge clk);
    cfg_wr_en     <= 1'b1;
    cfg_wr_data   <= v;
    degree_shadow = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // Coordinate driver: hold a presented transaction until taken, else maybe idle
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        expand_coord(coord_q.pop_front());
      end
      if (!in_tvalid || in_tready) begin
        if (coord_q.size() != 0 && (calm || $urandom_range(99) >= GAP_PCT)) begin
          in_tvalid <= 1'b1;
          in_tdata  <= {{(IN_W - W_COORD){1'b0}}, coord_q[0]};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin : result_monitor
    basis_res_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (basis_q.size() == 0) begin
          $error("result transaction with no expectation: tdata %h", out_tdata);
          n_errors++;
        end else begin
          want = basis_q.pop_front();
          if (out_tdata[W_DEGREE-1:0] !== want.degree) begin
            $error("degree expected %0d actual %0d", want.degree, out_tdata[W_DEGREE-1:0]);
            n_errors++;
          end
          if (out_tdata[OFS_VAL +: W_VAL] !== want.poly_value) begin
            $error("poly_value expected %0d actual %0d", $signed(want.poly_value),
                   $signed(out_tdata[OFS_VAL +: W_VAL]));
            n_errors++;
          end
          if (out_tdata[OFS_D1 +: W_D1] !== want.first_deriv) begin
            $error("first_deriv expected %0d actual %0d", $signed(want.first_deriv),
                   $signed(out_tdata[OFS_D1 +: W_D1]));
            n_errors++;
          end
          if (out_tdata[OFS_D2 +: W_D2] !== want.second_deriv) begin
            $error("second_deriv expected %0d actual %0d", $signed(want.second_deriv),
                   $signed(out_tdata[OFS_D2 +: W_D2]));
            n_errors++;
          end
          if (out_tlast !== want.last) begin
            $error("last expected %0d actual %0d", want.last, out_tlast);
            n_errors++;
          end
        end
      end
      out_tready <= calm || ($urandom_range(99) >= GAP_PCT);
    end
  end

  // Watchdog: abort when no transaction moves on either side for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus: corners at the reset degree, degree edge cases, then random phases
  initial begin : stimulus
    logic [3:0] deg;
    int         pick;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (CORNER_X[i]) coord_q.push_back(W_COORD'(CORNER_X[i]));
    settle();

    // Degree zero: a single marked result per coordinate
    set_degree(4'd0);
    coord_q.push_back(W_COORD'(0));
    coord_q.push_back(W_COORD'(65536));
    coord_q.push_back(W_COORD'(-131072));
    settle();

    // Degree above the maximum: clamp to the maximum
    set_degree(4'd15);
    coord_q.push_back(W_COORD'(65536));
    coord_q.push_back(W_COORD'(-65536));
    coord_q.push_back(W_COORD'(131071));
    settle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: deg = 4'd1;
        1: deg = 4'd11;
        2: deg = 4'd10;
        default: deg = 4'($urandom_range(15));
      endcase
      set_degree(deg);
      calm = (p == 4);
      for (int k = 0; k < 22; k++) begin
        pick = $urandom_range(99);
        if (pick < 80) begin
          coord_q.push_back(W_COORD'($urandom_range(131072) - 65536));
        end else if (pick < 90) begin
          coord_q.push_back(W_COORD'(CORNER_X[$urandom_range(2)]));
        end else begin
          coord_q.push_back(W_COORD'($urandom));
        end
      end
      settle();
    end
    calm = 1'b0;

    // Drain: catch any stray result after the last expectation
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0 && basis_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
